[design/bmd_pkg.sv]
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types and constants for the banked memory map decoder.
// ----------------------------------------------------------------------------
package bmd_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned ROM_BANK_BITS = 14;  // 16 KiB ROM banks
  localparam int unsigned RAM_BANK_BITS = 13;  // 8 KiB ext RAM banks

  // Cartridge controller kinds
  localparam logic [1:0] CART_ROM  = 2'd0;
  localparam logic [1:0] CART_MBC1 = 2'd1;
  localparam logic [1:0] CART_MBC3 = 2'd2;

  // Controller write selects, address bits 14:13
  localparam logic [1:0] SEL_RAM_EN   = 2'd0;
  localparam logic [1:0] SEL_ROM_LOW  = 2'd1;
  localparam logic [1:0] SEL_BANK_HI  = 2'd2;
  localparam logic [1:0] SEL_MODE     = 2'd3;

  // Configuration register indexes (paddr bit 2)
  localparam logic CFG_CART_KIND = 1'b0;
  localparam logic CFG_BOOT_OVL  = 1'b1;

  // Special addresses and range limits
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_JOYP = 16'hFF00;
  localparam logic [15:0] WRAM_END  = 16'hFDFF;
  localparam logic [15:0] OAM_END   = 16'hFE9F;
  localparam logic [15:0] IO_END    = 16'hFF7F;
  localparam logic [7:0]  RAM_EN_KEY = 8'h0A;
  localparam logic [3:0]  VIDEO_HI  = 4'h4;

  typedef enum logic [3:0] {
    RG_BOOT  = 4'd0,
    RG_ROM   = 4'd1,
    RG_VRAM  = 4'd2,
    RG_ERAM  = 4'd3,
    RG_WRAM  = 4'd4,
    RG_OAM   = 4'd5,
    RG_JOYP  = 4'd6,
    RG_VIDEO = 4'd7,
    RG_IO    = 4'd8,
    RG_HRAM  = 4'd9,
    RG_NONE  = 4'd10,
    RG_DMA   = 4'd11
  } region_t;

  typedef struct packed {
    logic [7:0] rom_page;
    logic [1:0] ram_page;
    logic       ram_en;
    logic       bank_mode;
  } bank_state_t;

  typedef struct packed {
    region_t               region;
    logic [OFFSET_W-1:0]   offset;
    logic                  store_enable;
    logic [7:0]            store_byte;
    logic                  rom_write_error;
    logic                  ext_ram_enabled;
  } result_t;

endpackage

[design/bmd_decode.sv]
// ----------------------------------------------------------------------------
// bmd_decode
// Address decode: bus address to target region and physical offset.
// ----------------------------------------------------------------------------
module bmd_decode (
  input  logic [15:0]          address,
  input  logic [1:0]           cart_kind,
  input  logic                 boot_overlay_on,
  input  bmd_pkg::bank_state_t bank,
  output bmd_pkg::region_t     region,
  output logic [20:0]          offset
);

  always_comb begin
    region = bmd_pkg::RG_NONE;
    offset = '0;
    if (address[15:14] == 2'b00) begin
      region = (address[15:8] == 8'h00 && boot_overlay_on) ? bmd_pkg::RG_BOOT
                                                           : bmd_pkg::RG_ROM;
      offset = {5'd0, address};
    end else if (address[15:14] == 2'b01) begin
      region = bmd_pkg::RG_ROM;
      if (cart_kind != bmd_pkg::CART_ROM) begin
        // bank bit 7 falls off the 21-bit offset
        offset = {bank.rom_page[6:0], address[bmd_pkg::ROM_BANK_BITS-1:0]};
      end else begin
        offset = {5'd0, address};
      end
    end else if (address[15:13] == 3'b100) begin
      region = bmd_pkg::RG_VRAM;
      offset = {8'd0, address[12:0]};
    end else if (address[15:13] == 3'b101) begin
      region = bmd_pkg::RG_ERAM;
      offset = {6'd0, bank.ram_page, address[bmd_pkg::RAM_BANK_BITS-1:0]};
    end else if (address <= bmd_pkg::WRAM_END) begin
      // 0xC000 and the echo at 0xE000 both reduce to the low 13 bits
      region = bmd_pkg::RG_WRAM;
      offset = {8'd0, address[12:0]};
    end else if (address <= bmd_pkg::OAM_END) begin
      region = bmd_pkg::RG_OAM;
      offset = {13'd0, address[7:0]};
    end else if (address <= bmd_pkg::IO_END) begin
      if (address == bmd_pkg::ADDR_JOYP) begin
        region = bmd_pkg::RG_JOYP;
        offset = '0;
      end else if (address[7:4] == bmd_pkg::VIDEO_HI) begin
        region = bmd_pkg::RG_VIDEO;
        offset = {5'd0, address};
      end else begin
        region = bmd_pkg::RG_IO;
        offset = {5'd0, address};
      end
    end else begin
      region = bmd_pkg::RG_HRAM;
      offset = {14'd0, address[6:0]};
    end
  end

endmodule

[design/bmd_ctrl.sv]
// ----------------------------------------------------------------------------
// bmd_ctrl
// MBC1 / MBC3 bank registers and their update on ROM-area writes.
// ----------------------------------------------------------------------------
module bmd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,       // commit a ROM-area write
  input  logic [15:0]          address,
  input  logic [7:0]           wdata,
  input  logic [1:0]           cart_kind,
  output bmd_pkg::bank_state_t bank,        // state before this item
  output logic                 ram_en_nxt,  // enable flag after this item
  output logic                 wr_err
);

  bmd_pkg::bank_state_t bank_r;
  bmd_pkg::bank_state_t bank_nxt;
  logic [4:0]           low_bank;

  always_comb begin
    bank_nxt = bank_r;
    wr_err   = 1'b0;
    low_bank = (wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0];
    case (address[14:13])
      bmd_pkg::SEL_RAM_EN: begin
        if (cart_kind == bmd_pkg::CART_ROM) begin
          wr_err = 1'b1;
        end else begin
          bank_nxt.ram_en = (wdata == bmd_pkg::RAM_EN_KEY);
        end
      end
      bmd_pkg::SEL_ROM_LOW: begin
        if (cart_kind == bmd_pkg::CART_MBC1) begin
          bank_nxt.rom_page = {bank_r.rom_page[7:6], 1'b0, low_bank};
        end else if (cart_kind == bmd_pkg::CART_MBC3) begin
          bank_nxt.rom_page = {1'b0, wdata[6:0]};
        end else begin
          wr_err = 1'b1;
        end
      end
      bmd_pkg::SEL_BANK_HI: begin
        if (cart_kind != bmd_pkg::CART_MBC1) begin
          wr_err = 1'b1;
        end else if (bank_r.bank_mode) begin
          bank_nxt.ram_page = wdata[1:0];
        end else begin
          bank_nxt.rom_page = {wdata[1:0], bank_r.rom_page[5:0]};
        end
      end
      bmd_pkg::SEL_MODE: begin
        if (cart_kind != bmd_pkg::CART_MBC1) begin
          wr_err = 1'b1;
        end else begin
          bank_nxt.bank_mode = wdata[0];
        end
      end
      default: begin
        wr_err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '{rom_page: 8'd1, ram_page: 2'd0, ram_en: 1'b1, bank_mode: 1'b0};
    end else if (wr_en) begin
      bank_r <= bank_nxt;
    end
  end

  assign bank       = bank_r;
  assign ram_en_nxt = wr_en ? bank_nxt.ram_en : bank_r.ram_en;

endmodule

[design/banked_memory_map_decoder.sv]
// ----------------------------------------------------------------------------
// banked_memory_map_decoder
// Decodes CPU bus accesses to region and offset with MBC1 / MBC3 banking.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                Handshake
//  -------  -----------------------------------  ---------------------------
//  in       in_mode, in_address, in_wdata        in_valid / in_ready
//  out      out_region, out_offset, out_store_*, out_valid / out_ready
//           out_rom_write_error,
//           out_ext_ram_enabled
//  cfg      psel, penable, pwrite, paddr,        APB, pready tied high
//           pwdata, prdata, pready
//
//  Two register stages: an input register and a result register. An accepted
//  item moves from the input register to the result register, which presents
//  it; one item per cycle is sustained while out_ready stays high.
//  The bank registers change when an item moves from the input register to
//  the result register, so later items always see earlier updates.
//  A stall on out_ready holds the result register; the input register still
//  fills, and in_ready drops only when both stages hold an item and
//  out_ready is low.
//  Synchronous active-low reset clears both valid flags and resets the
//  bank registers (ROM bank 1, RAM bank 0, RAM enabled, mode 0) and configuration.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_wdata,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_region,
  output logic [20:0] out_offset,
  output logic        out_store_enable,
  output logic [7:0]  out_store_byte,
  output logic        out_rom_write_error,
  output logic        out_ext_ram_enabled,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [1:0] cart_kind_r;
  logic       boot_ovl_r;
  logic       cfg_wr;

  // Input register
  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_wdata_r;

  // Result register
  logic              out_valid_r;
  bmd_pkg::result_t  res_r;
  bmd_pkg::result_t  res_nxt;

  logic out_free;
  logic s1_adv;
  logic in_acc;
  logic ctrl_wr;

  bmd_pkg::bank_state_t bank;
  bmd_pkg::region_t     dec_region;
  logic [20:0]          dec_offset;
  logic                 ram_en_nxt;
  logic                 ctrl_err;

  // --- configuration port ---
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_kind_r <= bmd_pkg::CART_ROM;
      boot_ovl_r  <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == bmd_pkg::CFG_CART_KIND) begin
        cart_kind_r <= pwdata[1:0];
      end else begin
        boot_ovl_r <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == bmd_pkg::CFG_BOOT_OVL) ? {31'd0, boot_ovl_r}
                                                      : {30'd0, cart_kind_r};

  // --- handshake / pipeline control ---
  assign out_free = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | out_free;
  assign in_acc   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_mode;
      s1_addr_r  <= in_address;
      s1_wdata_r <= in_wdata;
    end
  end

  // Bank registers move only on a committed write below 0x8000
  assign ctrl_wr = s1_adv & s1_mode_r & ~s1_addr_r[15];

  bmd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (ctrl_wr),
    .address    (s1_addr_r),
    .wdata      (s1_wdata_r),
    .cart_kind  (cart_kind_r),
    .bank       (bank),
    .ram_en_nxt (ram_en_nxt),
    .wr_err     (ctrl_err)
  );

  bmd_decode u_decode (
    .address         (s1_addr_r),
    .cart_kind       (cart_kind_r),
    .boot_overlay_on (boot_ovl_r),
    .bank            (bank),
    .region          (dec_region),
    .offset          (dec_offset)
  );

  // --- result assembly ---
  always_comb begin
    res_nxt.region          = bmd_pkg::RG_NONE;
    res_nxt.offset          = '0;
    res_nxt.store_enable    = 1'b0;
    res_nxt.store_byte      = '0;
    res_nxt.rom_write_error = 1'b0;
    res_nxt.ext_ram_enabled = ram_en_nxt;
    if (!s1_mode_r) begin
      // read
      res_nxt.region = dec_region;
      res_nxt.offset = dec_offset;
    end else if (!s1_addr_r[15]) begin
      // controller write, no target region
      res_nxt.rom_write_error = ctrl_err;
    end else if (s1_addr_r == bmd_pkg::ADDR_DMA) begin
      // DMA start: source page in the offset
      res_nxt.region = bmd_pkg::RG_DMA;
      res_nxt.offset = {5'd0, s1_wdata_r, 8'd0};
    end else begin
      res_nxt.region       = dec_region;
      res_nxt.offset       = dec_offset;
      res_nxt.store_enable = 1'b1;
      // divider write always clears it
      res_nxt.store_byte   = (s1_addr_r == bmd_pkg::ADDR_DIV) ? 8'd0 : s1_wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_region          = res_r.region;
  assign out_offset          = res_r.offset;
  assign out_store_enable    = res_r.store_enable;
  assign out_store_byte      = res_r.store_byte;
  assign out_rom_write_error = res_r.rom_write_error;
  assign out_ext_ram_enabled = res_r.ext_ram_enabled;

`ifndef SYNTH
  // Backpressure only when both stages hold an item
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low with a free stage");

  // A flagged ROM write never targets a region
  a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rom_write_error) |->
      (out_region == bmd_pkg::RG_NONE && !out_store_enable))
    else $error("ROM write error with a target region");

  // DMA start carries a page-aligned source and no store
  a_dma_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == bmd_pkg::RG_DMA) |->
      (out_offset[7:0] == 8'd0 && !out_store_enable && out_offset[20:16] == 5'd0))
    else $error("malformed DMA start");

  // Bank registers only move when an item leaves the input register
  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl_wr |=> $stable(bank))
    else $error("bank registers changed without a controller write");

  // Stores never come from the no-target region or a DMA start
  a_store_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_store_enable) |->
      (out_region != bmd_pkg::RG_NONE && out_region != bmd_pkg::RG_DMA))
    else $error("store without a target region");
`endif

endmodule

[tb/bmd_decode_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmd_decode_checker
// Watches the access, result and register ports of the memory map decoder.
// It keeps its own bank state and settings, predicts one decode per accepted
// access, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module bmd_decode_checker (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [15:0]        in_address,
  input  logic [7:0]         in_wdata,

  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_region,
  input  logic [20:0]        out_offset,
  input  logic               out_store_enable,
  input  logic [7:0]         out_store_byte,
  input  logic               out_rom_write_error,
  input  logic               out_ext_ram_enabled,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,

  output int unsigned        mismatches,
  output int unsigned        outstanding
);

  // settings and bank state as the decoder should hold them
  logic [1:0] cart_kind;
  logic       boot_ovl;
  logic [7:0] rom_page;
  logic [1:0] ram_page;
  logic       ram_en;
  logic       bank_mode;

  bmd_pkg::result_t pending_decodes[$];
  int unsigned      fail_total = 0;

  assign mismatches = fail_total;

  function automatic void map_address(input logic [15:0] a,
                                      output bmd_pkg::region_t rg,
                                      output logic [20:0] off);
    logic [31:0] full;
    full = 32'(a);
    if (a < 16'h4000) begin
      rg = (a <= 16'h00FF && boot_ovl) ? bmd_pkg::RG_BOOT : bmd_pkg::RG_ROM;
    end else if (a < 16'h8000) begin
      rg = bmd_pkg::RG_ROM;
      if (cart_kind != bmd_pkg::CART_ROM)
        full = (32'(rom_page) << bmd_pkg::ROM_BANK_BITS) + 32'(a - 16'h4000);
    end else if (a < 16'hA000) begin
      rg = bmd_pkg::RG_VRAM;
      full = 32'(a - 16'h8000);
    end else if (a < 16'hC000) begin
      rg = bmd_pkg::RG_ERAM;
      full = (32'(ram_page) << bmd_pkg::RAM_BANK_BITS) + 32'(a - 16'hA000);
    end else if (a < 16'hE000) begin
      rg = bmd_pkg::RG_WRAM;
      full = 32'(a - 16'hC000);
    end else if (a <= bmd_pkg::WRAM_END) begin
      rg = bmd_pkg::RG_WRAM;              // echo of work RAM
      full = 32'(a - 16'hE000);
    end else if (a <= bmd_pkg::OAM_END) begin
      rg = bmd_pkg::RG_OAM;
      full = 32'(a - 16'hFE00);
    end else if (a <= bmd_pkg::IO_END) begin
      if (a == bmd_pkg::ADDR_JOYP) begin
        rg = bmd_pkg::RG_JOYP;
        full = 32'd0;
      end else if (a[7:4] == bmd_pkg::VIDEO_HI) begin
        rg = bmd_pkg::RG_VIDEO;
      end else begin
        rg = bmd_pkg::RG_IO;
      end
    end else begin
      rg = bmd_pkg::RG_HRAM;
      full = 32'(a - 16'hFF80);
    end
    off = full[20:0];                     // bank bit 7 wraps out here
  endfunction

  // write below 0x8000; returns 1 when the controller ignores it
  function automatic logic bank_write(input logic [15:0] a, input logic [7:0] v);
    logic [4:0] low;
    case (a[14:13])
      bmd_pkg::SEL_RAM_EN: begin
        if (cart_kind == bmd_pkg::CART_ROM) return 1'b1;
        ram_en = (v == bmd_pkg::RAM_EN_KEY);
        return 1'b0;
      end
      bmd_pkg::SEL_ROM_LOW: begin
        if (cart_kind == bmd_pkg::CART_MBC1) begin
          low = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
          rom_page = {rom_page[7:6], 1'b0, low};
          return 1'b0;
        end
        if (cart_kind == bmd_pkg::CART_MBC3) begin
          rom_page = {1'b0, v[6:0]};
          return 1'b0;
        end
        return 1'b1;
      end
      bmd_pkg::SEL_BANK_HI: begin
        if (cart_kind != bmd_pkg::CART_MBC1) return 1'b1;
        if (bank_mode) ram_page = v[1:0];
        else rom_page = {v[1:0], rom_page[5:0]};
        return 1'b0;
      end
      default: begin
        if (cart_kind != bmd_pkg::CART_MBC1) return 1'b1;
        bank_mode = v[0];
        return 1'b0;
      end
    endcase
  endfunction

  function automatic bmd_pkg::result_t predict_access(input logic is_write,
                                                      input logic [15:0] a,
                                                      input logic [7:0] v);
    bmd_pkg::result_t r;
    bmd_pkg::region_t rg;
    logic [20:0]      off;
    r = '0;
    r.region = bmd_pkg::RG_NONE;
    if (!is_write) begin
      map_address(a, rg, off);
      r.region = rg;
      r.offset = off;
    end else if (a < 16'h8000) begin
      r.rom_write_error = bank_write(a, v);
    end else if (a == bmd_pkg::ADDR_DMA) begin
      r.region = bmd_pkg::RG_DMA;
      r.offset = {5'd0, v, 8'd0};
    end else begin
      map_address(a, rg, off);
      r.region = rg;
      r.offset = off;
      r.store_enable = 1'b1;
      r.store_byte = (a == bmd_pkg::ADDR_DIV) ? 8'd0 : v;
    end
    r.ext_ram_enabled = ram_en;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    bmd_pkg::result_t want;
    if (!rst_n) begin
      cart_kind = bmd_pkg::CART_ROM;
      boot_ovl  = 1'b1;
      rom_page  = 8'd1;
      ram_page  = 2'd0;
      ram_en    = 1'b1;
      bank_mode = 1'b0;
      pending_decodes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bmd_pkg::CFG_BOOT_OVL) boot_ovl = pwdata[0];
        else cart_kind = pwdata[1:0];
      end
      // results leave only after their access is accepted, so pop first
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          $error("result with no access pending");
          fail_total++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("region", 32'(want.region), 32'(out_region));
          check_field("offset", 32'(want.offset), 32'(out_offset));
          check_field("store_enable", 32'(want.store_enable), 32'(out_store_enable));
          check_field("store_byte", 32'(want.store_byte), 32'(out_store_byte));
          check_field("rom_write_error", 32'(want.rom_write_error),
                      32'(out_rom_write_error));
          check_field("ext_ram_enabled", 32'(want.ext_ram_enabled),
                      32'(out_ext_ram_enabled));
        end
      end
      if (in_valid && in_ready)
        pending_decodes.push_back(predict_access(in_mode, in_address, in_wdata));
    end
    outstanding <= pending_decodes.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the banked memory map decoder. A short directed
// pass hits the map edges and the bank controller corner cases, then random
// bus accesses run under each cartridge kind and overlay setting while both
// channel sides idle at random. Checking lives in bmd_decode_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic        ACC_READ    = 1'b0;
  localparam logic        ACC_WRITE   = 1'b1;
  localparam logic [1:0]  CART_KIND_X = 2'd3;    // undefined kind, still decoded
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASE_ITEMS = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = ACC_READ;
  logic [15:0] in_address = '0;
  logic [7:0]  in_wdata = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_region;
  logic [20:0] out_offset;
  logic        out_store_enable;
  logic [7:0]  out_store_byte;
  logic        out_rom_write_error;
  logic        out_ext_ram_enabled;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned in_calm = 0;      // items left in a stretch with no input gaps

  always #1 clk = ~clk;

  banked_memory_map_decoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_wdata            (in_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_region          (out_region),
    .out_offset          (out_offset),
    .out_store_enable    (out_store_enable),
    .out_store_byte      (out_store_byte),
    .out_rom_write_error (out_rom_write_error),
    .out_ext_ram_enabled (out_ext_ram_enabled),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  bmd_decode_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_wdata            (in_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_region          (out_region),
    .out_offset          (out_offset),
    .out_store_enable    (out_store_enable),
    .out_store_byte      (out_store_byte),
    .out_rom_write_error (out_rom_write_error),
    .out_ext_ram_enabled (out_ext_ram_enabled),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  // Hard stop. Counts from time zero so the reset window is included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side back-pressure. Each time a hold runs out a new level and hold
  // length are drawn: mostly short ready/stall spells, sometimes a long stall,
  // sometimes a long run of steady ready. One assignment per edge at most.
  initial begin : result_sink
    int unsigned hold;
    int unsigned roll;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          out_ready <= 1'b1;
          hold = $urandom_range(30, 80);
        end else if (roll < 60) begin
          out_ready <= 1'b1;
          hold = $urandom_range(0, 4);
        end else if (roll < 92) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(5, 25);
        end
      end
    end
  end

  // Present one item after a random gap and hold it until the decoder takes
  // it. Returns in the time step of the accepting edge, with nothing assigned
  // yet in that step, so the caller may drive the next item right away.
  task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
    int unsigned gap;
    int unsigned roll;
    gap = 0;
    if (in_calm > 0) begin
      in_calm--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) in_calm = $urandom_range(20, 60);
      else if (roll < 55) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 24);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= wr;
    in_address <= a;
    in_wdata   <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random access, weighted toward the parts of the map that hold state or
  // special decodes. Writes dominate the controller area so the bank
  // registers keep moving.
  task automatic send_random_access();
    int unsigned roll;
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    roll = $urandom_range(0, 99);
    wr   = 1'($urandom_range(0, 1));
    a    = 16'($urandom_range(0, 16'hFFFF));
    d    = 8'($urandom_range(0, 255));
    if (roll < 35) begin
      a[15] = 1'b0;
      wr = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: d = bmd_pkg::RAM_EN_KEY;
        1: d[4:0] = 5'd0;               // bank 0 request, remapped to 1
        default: ;
      endcase
    end else if (roll < 50) begin
      a = {2'b01, a[13:0]};             // switchable ROM window
    end else if (roll < 58) begin
      a = 16'($urandom_range(16'h00F0, 16'h010F));   // boot overlay edge
    end else if (roll < 63) begin
      a = bmd_pkg::ADDR_DMA;
    end else if (roll < 67) begin
      a = bmd_pkg::ADDR_DIV;
    end else if (roll < 71) begin
      a = bmd_pkg::ADDR_JOYP;
    end else if (roll < 81) begin
      a = {7'h7F, a[8:0]};              // OAM, io and high RAM
    end else if (roll < 90) begin
      a = {3'b101, a[12:0]};            // banked external RAM
    end
    send_access(wr, a, d);
  endtask

  // Write: setup phase, then access phase. Lands at the edge that sees penable.
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and wait for every predicted result, and for the two decoder
  // stages to be surely empty before settings change.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] kind, input logic ovl, input int unsigned n);
    settle();
    cfg_write(bmd_pkg::CFG_CART_KIND, 32'(kind));
    cfg_write(bmd_pkg::CFG_BOOT_OVL, 32'(ovl));
    repeat (n) send_random_access();
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: plain ROM cart, boot overlay on.
    send_access(ACC_READ,  16'h0000, 8'h00);   // boot ROM, lowest
    send_access(ACC_READ,  16'h00FF, 8'hFF);   // boot ROM, highest
    send_access(ACC_READ,  16'h0100, 8'h00);   // first cart byte past overlay
    send_access(ACC_READ,  16'h4000, 8'h00);   // no banking without controller
    send_access(ACC_READ,  16'hFFFF, 8'h00);   // top of high RAM
    send_access(ACC_READ,  bmd_pkg::ADDR_JOYP, 8'h00);
    send_access(ACC_READ,  bmd_pkg::ADDR_DMA, 8'hFF);  // a read of the DMA reg is a video reg
    send_access(ACC_WRITE, 16'h2000, 8'h05);   // ROM write with no controller
    send_access(ACC_WRITE, bmd_pkg::ADDR_DMA, 8'hFF);  // DMA start, source page FF
    send_access(ACC_WRITE, bmd_pkg::ADDR_DIV, 8'hAB);  // divider write stores zero
    send_access(ACC_WRITE, 16'hE000, 8'h5A);   // echo RAM
    send_access(ACC_WRITE, 16'hFEA0, 8'h3C);   // first io address past OAM
    settle();

    // MBC1, overlay off: RAM enable key, bank 0 remap, upper bank bits and
    // offset wrap, mode switch to RAM banking.
    cfg_write(bmd_pkg::CFG_CART_KIND, 32'(bmd_pkg::CART_MBC1));
    cfg_write(bmd_pkg::CFG_BOOT_OVL, 32'd0);
    send_access(ACC_WRITE, 16'h0000, bmd_pkg::RAM_EN_KEY);
    send_access(ACC_WRITE, 16'h1FFF, 8'h00);   // any other value disables
    send_access(ACC_WRITE, 16'h2000, 8'h00);   // bank 0 reads back as 1
    send_access(ACC_WRITE, 16'h4000, 8'hFF);   // upper bits into bank 7:6
    send_access(ACC_READ,  16'h7FFF, 8'h00);   // bank bit 7 drops out
    send_access(ACC_WRITE, 16'h6000, 8'h01);   // RAM banking mode
    send_access(ACC_WRITE, 16'h5FFF, 8'h03);   // RAM bank 3
    send_access(ACC_READ,  16'hBFFF, 8'h00);
    send_access(ACC_READ,  16'h0000, 8'h00);   // overlay off: cart ROM
    repeat (PHASE_ITEMS) send_random_access();

    // MBC3 with overlay, the undefined kind, then back to no controller.
    run_phase(bmd_pkg::CART_MBC3, 1'b1, PHASE_ITEMS);
    run_phase(CART_KIND_X, 1'b0, PHASE_ITEMS);
    run_phase(bmd_pkg::CART_ROM, 1'b0, PHASE_ITEMS);

    // Drain; anything that never arrives ends in the cycle limit.
    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
